// File: rtl/cmof_pkg.sv
// ----------------------------------------------------------------------------
// cmof_pkg
// Shared types, codes and helpers of the conditional median outlier filter.
// ----------------------------------------------------------------------------
package cmof_pkg;

	localparam int COMP_W   = 32;
	localparam int PIX_W    = 3 * COMP_W;
	localparam int PEAK_W   = 31;
	localparam int SUM_W    = 47;
	localparam int CNT_W    = 17;
	localparam int FACTOR_W = 16;
	localparam int DIM_W    = 9;
	localparam int RAD_W    = 2;
	localparam int CFG_A_W  = 3;
	localparam int CFG_D_W  = 16;
	localparam int OUT_D_W  = PIX_W + 2 * CNT_W + 2 * SUM_W;

	localparam logic [RAD_W-1:0]    RADIUS_RST = 2'd1;
	localparam logic [FACTOR_W-1:0] FACTOR_RST = 16'd1024;
	localparam logic [DIM_W-1:0]    DIM_RST    = 9'd256;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_EMIT = 1'b1
	} op_t;

	typedef enum logic [CFG_A_W-1:0] {
		REG_ENABLE = 3'd0,
		REG_RADIUS = 3'd1,
		REG_FACTOR = 3'd2,
		REG_WIDTH  = 3'd3,
		REG_HEIGHT = 3'd4
	} reg_idx_t;

	typedef enum logic [1:0] {
		RD_CENTER = 2'd0,
		RD_SCAN   = 2'd1,
		RD_MEDIAN = 2'd2
	} rd_sel_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CRD,
		ST_CLAT,
		ST_DIV,
		ST_SETUP,
		ST_SCAN,
		ST_DRAIN,
		ST_SHIFT,
		ST_MRD,
		ST_MLAT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic    load_wr;
		logic    emit_start;
		logic    lat_center;
		logic    lat_pass;
		logic    div_init;
		logic    div_step;
		logic    setup;
		logic    scan_step;
		logic    shift_step;
		logic    lat_med;
		logic    out_load;
		rd_sel_t rd_sel;
	} cmd_t;

	typedef struct packed {
		logic disabled;
		logic div_last;
		logic scan_last;
		logic pipe_busy;
		logic shift_done;
		logic out_free;
	} sts_t;

	// max(0, r, g, b) of a packed pixel, red in the lowest bits
	function automatic logic [PEAK_W-1:0] peak_of(input logic [PIX_W-1:0] px);
		logic signed [COMP_W-1:0] m;
		logic signed [COMP_W-1:0] c;
		m = '0;
		for (int i = 0; i < 3; i++) begin
			c = px[i*COMP_W +: COMP_W];
			if (c > m) begin
				m = c;
			end
		end
		return m[PEAK_W-1:0];
	endfunction

endpackage

// File: rtl/cmof_ram.sv
// ----------------------------------------------------------------------------
// cmof_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module cmof_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/cmof_ctrl.sv
// ----------------------------------------------------------------------------
// cmof_ctrl
// Sequencer: writes load items and steps one emit item through center
// read, divide, tap scan, median selection and result hand-off.
// ----------------------------------------------------------------------------
module cmof_ctrl
	import cmof_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic in_op,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		cmd.rd_sel = RD_CENTER;
		in_ready   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (in_op == OP_LOAD) begin
						cmd.load_wr = 1'b1;
					end else begin
						cmd.emit_start = 1'b1;
						state_d        = ST_CRD;
					end
				end
			end
			ST_CRD: begin
				cmd.rd_sel = RD_CENTER;
				state_d    = ST_CLAT;
			end
			ST_CLAT: begin
				cmd.lat_center = 1'b1;
				if (sts.disabled) begin
					cmd.lat_pass = 1'b1;
					state_d      = ST_OUT;
				end else begin
					cmd.div_init = 1'b1;
					state_d      = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) begin
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: begin
				cmd.setup = 1'b1;
				state_d   = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.rd_sel    = RD_SCAN;
				cmd.scan_step = 1'b1;
				if (sts.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!sts.pipe_busy) begin
					state_d = ST_SHIFT;
				end
			end
			ST_SHIFT: begin
				if (sts.shift_done) begin
					state_d = ST_MRD;
				end else begin
					cmd.shift_step = 1'b1;
				end
			end
			ST_MRD: begin
				cmd.rd_sel = RD_MEDIAN;
				state_d    = ST_MLAT;
			end
			ST_MLAT: begin
				cmd.lat_med = 1'b1;
				state_d     = ST_OUT;
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/cmof_dp.sv
// ----------------------------------------------------------------------------
// cmof_dp
// Datapath: configuration, frame store, serial divider, tap scan, sorted
// insertion cells, threshold test, tallies and output register.
// ----------------------------------------------------------------------------
module cmof_dp
	import cmof_pkg::*;
#(
	parameter int MAX_RADIUS = 3,
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic [PIX_W-1:0]   in_pix,
	input  logic               cfg_we,
	input  logic [CFG_A_W-1:0] cfg_addr,
	input  logic [CFG_D_W-1:0] cfg_wdata,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [OUT_D_W-1:0] out_data,
	output logic               out_replaced,
	output logic               out_last
);

	localparam int WB    = $clog2(MAX_WIDTH + 1);
	localparam int HB    = $clog2(MAX_HEIGHT + 1);
	localparam int RB    = $clog2(MAX_RADIUS + 1);
	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int NB    = WB + HB;
	localparam int NT    = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
	localparam int TB    = $clog2(NT + 1);
	localparam int DB    = $clog2(AW + 1);

	// configuration
	logic                enable_q;
	logic [RAD_W-1:0]    radius_q;
	logic [FACTOR_W-1:0] factor_q;
	logic [DIM_W-1:0]    width_q;
	logic [DIM_W-1:0]    height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q <= 1'b1;
			radius_q <= RADIUS_RST;
			factor_q <= FACTOR_RST;
			width_q  <= DIM_RST;
			height_q <= DIM_RST;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_ENABLE: enable_q <= cfg_wdata[0];
				REG_RADIUS: radius_q <= cfg_wdata[RAD_W-1:0];
				REG_FACTOR: factor_q <= cfg_wdata[FACTOR_W-1:0];
				REG_WIDTH:  width_q  <= cfg_wdata[DIM_W-1:0];
				REG_HEIGHT: height_q <= cfg_wdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// clamped window size and radius
	logic [WB-1:0] w;
	logic [HB-1:0] h;
	logic [RB-1:0] rad;
	logic [NB-1:0] n;

	always_comb begin
		if (width_q == '0) begin
			w = WB'(1);
		end else if (32'(width_q) > 32'(MAX_WIDTH)) begin
			w = WB'(MAX_WIDTH);
		end else begin
			w = WB'(width_q);
		end
		if (height_q == '0) begin
			h = HB'(1);
		end else if (32'(height_q) > 32'(MAX_HEIGHT)) begin
			h = HB'(MAX_HEIGHT);
		end else begin
			h = HB'(height_q);
		end
		if (radius_q == '0) begin
			rad = RB'(1);
		end else if (32'(radius_q) > 32'(MAX_RADIUS)) begin
			rad = RB'(MAX_RADIUS);
		end else begin
			rad = RB'(radius_q);
		end
		n = NB'(w) * NB'(h);
	end

	// positions
	logic [AW-1:0] load_pos_q;
	logic [AW-1:0] emit_pos_q;
	logic [AW-1:0] lp;
	logic [AW-1:0] ep;
	logic [NB-1:0] lp1;
	logic [NB-1:0] ep1;

	always_comb begin
		lp  = (NB'(load_pos_q) < n) ? load_pos_q : '0;
		ep  = (NB'(emit_pos_q) < n) ? emit_pos_q : '0;
		lp1 = NB'(lp) + NB'(1);
		ep1 = NB'(ep) + NB'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_pos_q <= '0;
			emit_pos_q <= '0;
		end else begin
			if (cmd.load_wr) begin
				load_pos_q <= (lp1 >= n) ? '0 : AW'(lp1);
			end
			if (cmd.emit_start) begin
				emit_pos_q <= (ep1 >= n) ? '0 : AW'(ep1);
			end
		end
	end

	logic [AW-1:0] p_q;
	logic          pzero_q;
	logic          last_q;

	always_ff @(posedge clk) begin
		if (cmd.emit_start) begin
			p_q     <= ep;
			pzero_q <= (ep == '0);
			last_q  <= (NB'(ep) == n - NB'(1));
		end
	end

	// frame store
	logic [AW-1:0]    raddr;
	logic [AW-1:0]    scan_addr;
	logic [PIX_W-1:0] rdata;
	logic [AW-1:0]    cps_q [NT];

	always_comb begin
		unique case (cmd.rd_sel)
			RD_CENTER: raddr = p_q;
			RD_SCAN:   raddr = scan_addr;
			RD_MEDIAN: raddr = cps_q[0];
			default:   raddr = p_q;
		endcase
	end

	cmof_ram #(
		.WIDTH(PIX_W),
		.DEPTH(DEPTH)
	) u_store (
		.clk  (clk),
		.we   (cmd.load_wr),
		.waddr(lp),
		.wdata(in_pix),
		.raddr(raddr),
		.rdata(rdata)
	);

	// center pixel
	logic [PIX_W-1:0]  ctr_q;
	logic [PEAK_W-1:0] cpeak_q;

	always_ff @(posedge clk) begin
		if (cmd.lat_center) begin
			ctr_q   <= rdata;
			cpeak_q <= peak_of(rdata);
		end
	end

	// restoring divider: p / w, one quotient bit per step
	logic [AW-1:0] quo_q;
	logic [WB-1:0] rem_q;
	logic [DB-1:0] div_cnt_q;
	logic [WB:0]   r2;
	logic [WB:0]   r2s;
	logic          ge;

	always_comb begin
		r2  = {rem_q, quo_q[AW-1]};
		ge  = (r2 >= {1'b0, w});
		r2s = ge ? (r2 - {1'b0, w}) : r2;
	end

	always_ff @(posedge clk) begin
		if (cmd.div_init) begin
			quo_q     <= p_q;
			rem_q     <= '0;
			div_cnt_q <= '0;
		end else if (cmd.div_step) begin
			quo_q     <= {quo_q[AW-2:0], ge};
			rem_q     <= r2s[WB-1:0];
			div_cnt_q <= div_cnt_q + DB'(1);
		end
	end

	// neighborhood bounds and scan
	logic [WB-1:0] x;
	logic [HB-1:0] y;
	logic [WB:0]   x_hi;
	logic [HB:0]   y_hi;
	logic [WB-1:0] x0;
	logic [WB-1:0] x1;
	logic [HB-1:0] y0;
	logic [HB-1:0] y1;

	always_comb begin
		x    = rem_q;
		y    = HB'(quo_q);
		x_hi = {1'b0, x} + (WB+1)'(rad);
		y_hi = {1'b0, y} + (HB+1)'(rad);
		x0   = (x >= WB'(rad)) ? (x - WB'(rad)) : '0;
		y0   = (y >= HB'(rad)) ? (y - HB'(rad)) : '0;
		x1   = (x_hi >= {1'b0, w}) ? (w - WB'(1)) : x_hi[WB-1:0];
		y1   = (y_hi >= {1'b0, h}) ? (h - HB'(1)) : y_hi[HB-1:0];
	end

	logic [WB-1:0] x0_q;
	logic [WB-1:0] x1_q;
	logic [HB-1:0] y1_q;
	logic [WB-1:0] sx_q;
	logic [HB-1:0] sy_q;
	logic [AW-1:0] row_q;
	logic          row_end;

	assign scan_addr = row_q + AW'(sx_q);
	assign row_end   = (sx_q == x1_q);

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			x0_q  <= x0;
			x1_q  <= x1;
			y1_q  <= y1;
			sx_q  <= x0;
			sy_q  <= y0;
			row_q <= AW'(AW'(y0) * AW'(w));
		end else if (cmd.scan_step) begin
			if (row_end) begin
				sx_q  <= x0_q;
				sy_q  <= sy_q + HB'(1);
				row_q <= row_q + AW'(w);
			end else begin
				sx_q <= sx_q + WB'(1);
			end
		end
	end

	// read pipeline: address issue, read data, peak
	logic              vld_s1;
	logic              vld_s2;
	logic [AW-1:0]     pos_s1;
	logic [AW-1:0]     pos_s2;
	logic [PEAK_W-1:0] peak_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= cmd.scan_step;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		pos_s1  <= scan_addr;
		pos_s2  <= pos_s1;
		peak_s2 <= peak_of(rdata);
	end

	// sorted insertion cells; empty cells rank above everything
	logic [PEAK_W-1:0] cpk_q [NT];
	logic [NT-1:0]     cvl_q;
	logic [NT-1:0]     less;
	logic [NT-1:0]     take;
	logic [NT-1:0]     shf;
	logic [TB-1:0]     tap_cnt_q;
	logic [TB-1:0]     sh_cnt_q;

	always_comb begin
		for (int i = 0; i < NT; i++) begin
			less[i] = !cvl_q[i] || (peak_s2 < cpk_q[i]);
		end
		take[0] = less[0];
		shf[0]  = 1'b0;
		for (int i = 1; i < NT; i++) begin
			take[i] = less[i] && !less[i-1];
			shf[i]  = less[i] && less[i-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cvl_q <= '0;
		end else if (cmd.setup) begin
			cvl_q <= '0;
		end else if (vld_s2) begin
			cvl_q[0] <= 1'b1;
			for (int i = 1; i < NT; i++) begin
				if (take[i]) begin
					cvl_q[i] <= 1'b1;
				end else if (shf[i]) begin
					cvl_q[i] <= cvl_q[i-1];
				end
			end
		end else if (cmd.shift_step) begin
			for (int i = 0; i < NT - 1; i++) begin
				cvl_q[i] <= cvl_q[i+1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s2) begin
			for (int i = 0; i < NT; i++) begin
				if (take[i]) begin
					cpk_q[i] <= peak_s2;
					cps_q[i] <= pos_s2;
				end
			end
			for (int i = 1; i < NT; i++) begin
				if (shf[i]) begin
					cpk_q[i] <= cpk_q[i-1];
					cps_q[i] <= cps_q[i-1];
				end
			end
		end else if (cmd.shift_step) begin
			for (int i = 0; i < NT - 1; i++) begin
				cpk_q[i] <= cpk_q[i+1];
				cps_q[i] <= cps_q[i+1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.setup) begin
			tap_cnt_q <= '0;
			sh_cnt_q  <= '0;
		end else begin
			if (vld_s2) begin
				tap_cnt_q <= tap_cnt_q + TB'(1);
			end
			if (cmd.shift_step) begin
				sh_cnt_q <= sh_cnt_q + TB'(1);
			end
		end
	end

	// threshold product, registered before the compare
	logic [SUM_W-1:0]  prod_q;
	logic [PEAK_W-1:0] mpeak_q;

	always_ff @(posedge clk) begin
		if (cmd.rd_sel == RD_MEDIAN) begin
			prod_q  <= SUM_W'(factor_q) * SUM_W'(cpk_q[0]);
			mpeak_q <= cpk_q[0];
		end
	end

	// tallies and result
	logic [CNT_W-1:0] tally_q;
	logic [SUM_W-1:0] removed_q;
	logic [SUM_W-1:0] psum_q;
	logic [CNT_W-1:0] b_tally;
	logic [SUM_W-1:0] b_removed;
	logic [SUM_W-1:0] b_psum;
	logic             rep;
	logic [CNT_W-1:0] n_tally;
	logic [SUM_W-1:0] n_removed;
	logic [SUM_W-1:0] n_psum;

	always_comb begin
		b_tally   = pzero_q ? '0 : tally_q;
		b_removed = pzero_q ? '0 : removed_q;
		b_psum    = pzero_q ? '0 : psum_q;
		rep       = (SUM_W'({cpeak_q, 8'b0}) > prod_q);
		n_psum    = b_psum + SUM_W'(cpeak_q);
		n_tally   = rep ? (b_tally + CNT_W'(1)) : b_tally;
		n_removed = rep ? (b_removed + SUM_W'(cpeak_q) - SUM_W'(mpeak_q)) : b_removed;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tally_q   <= '0;
			removed_q <= '0;
			psum_q    <= '0;
		end else if (cmd.lat_med) begin
			tally_q   <= n_tally;
			removed_q <= n_removed;
			psum_q    <= n_psum;
		end else if (cmd.lat_pass) begin
			tally_q   <= b_tally;
			removed_q <= b_removed;
			psum_q    <= b_psum;
		end
	end

	logic [PIX_W-1:0] res_pix_q;
	logic             res_rep_q;
	logic [CNT_W-1:0] res_tally_q;
	logic [SUM_W-1:0] res_removed_q;
	logic [SUM_W-1:0] res_psum_q;
	logic [CNT_W-1:0] res_exam_q;

	always_ff @(posedge clk) begin
		if (cmd.lat_pass) begin
			res_pix_q     <= rdata;
			res_rep_q     <= 1'b0;
			res_tally_q   <= '0;
			res_removed_q <= '0;
			res_psum_q    <= '0;
			res_exam_q    <= '0;
		end else if (cmd.lat_med) begin
			res_pix_q     <= rep ? rdata : ctr_q;
			res_rep_q     <= rep;
			res_tally_q   <= n_tally;
			res_removed_q <= n_removed;
			res_psum_q    <= n_psum;
			res_exam_q    <= CNT_W'(n);
		end
	end

	// output register
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data     <= {res_exam_q, res_psum_q, res_removed_q, res_tally_q, res_pix_q};
			out_replaced <= res_rep_q;
			out_last     <= last_q;
		end
	end

	assign out_valid = out_valid_q;

	always_comb begin
		sts.disabled   = !enable_q;
		sts.div_last   = (div_cnt_q == DB'(AW - 1));
		sts.scan_last  = row_end && (sy_q == y1_q);
		sts.pipe_busy  = vld_s1 || vld_s2;
		sts.shift_done = (sh_cnt_q == (tap_cnt_q >> 1));
		sts.out_free   = !out_valid_q || out_ready;
	end

endmodule

// File: rtl/conditional_median_outlier_filter.sv
// ----------------------------------------------------------------------------
// conditional_median_outlier_filter
// Conditional median (firefly) filter over a stored RGB window.
// ----------------------------------------------------------------------------
// Load items (tuser 0) write one pixel per cycle into the frame store in
// raster order while no emit is in progress. Emit items (tuser 1) return
// the next pixel of the window, replaced while enabled by the neighborhood's
// upper-median pixel when its peak exceeds factor/256 times the median
// peak. An emit runs one item at a time through the serial divider that
// splits the position into column and row, then one frame-store read per
// tap through the single read port (up to 49 in-window taps at radius 3),
// then a shift of the sorted tap cells down to the median. A new item is
// accepted while a result still waits in the output register. The frame
// store needs no clearing.
// ----------------------------------------------------------------------------
module conditional_median_outlier_filter
	import cmof_pkg::*;
#(
	parameter int MAX_RADIUS = 3,
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [PIX_W-1:0]   s_tdata,   // red_in, green_in, blue_in
	input  logic               s_tuser,   // opcode
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [OUT_D_W-1:0] m_tdata,   // red_out, green_out, blue_out,
	                                      // replaced_count, energy_removed,
	                                      // energy_total, examined_count
	output logic               m_tuser,   // replaced
	output logic               m_tlast,   // last_pixel
	input  logic               cfg_we,
	input  logic [CFG_A_W-1:0] cfg_addr,
	input  logic [CFG_D_W-1:0] cfg_wdata
);

	cmd_t cmd;
	sts_t sts;

	cmof_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(s_tvalid),
		.in_op   (s_tuser),
		.in_ready(s_tready),
		.sts     (sts),
		.cmd     (cmd)
	);

	cmof_dp #(
		.MAX_RADIUS(MAX_RADIUS),
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.in_pix      (s_tdata),
		.cfg_we      (cfg_we),
		.cfg_addr    (cfg_addr),
		.cfg_wdata   (cfg_wdata),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_data    (m_tdata),
		.out_replaced(m_tuser),
		.out_last    (m_tlast)
	);

endmodule
